// ===== src/srdl_pkg.sv =====
// ----------------------------------------------------------------------------
// srdl_pkg
// Shared widths, register indexes and status types for the slewed ring
// delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package srdl_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned LEN_CFG_W      = 16;
  localparam int unsigned TGT_CFG_W      = 16;
  localparam int unsigned CNT_W          = 15;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned RING_DEPTH_DEF = 32768;
  localparam int unsigned LEN_RESET      = 32768;
  localparam int unsigned MIN_LEN        = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LENGTH = 2'd0,
    REG_TARGET_OFFSET = 2'd1,
    REG_RATE_HOLD     = 2'd2,
    REG_SLEW_INTERVAL = 2'd3
  } cfg_reg_e;

  // status of the memory access stage
  typedef struct packed {
    logic valid;
    logic fwd;
  } srdl_stage_t;

endpackage : srdl_pkg

`default_nettype wire

// ===== src/srdl_ring.sv =====
// ----------------------------------------------------------------------------
// srdl_ring
// Ring memory: one write and one registered read port, with a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module srdl_ring #(
  parameter int unsigned RING_DEPTH = srdl_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [AW-1:0]                 waddr_i,
  input  wire logic [srdl_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [AW-1:0]                 raddr_i,
  output logic      [srdl_pkg::SAMPLE_W-1:0] rdata_o,
  output logic                               busy_o
);
  import srdl_pkg::*;

  logic [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  logic                clearing_q, clearing_d;
  logic                clr_last;

  assign clr_last = (clr_addr_q == AW'(RING_DEPTH - 1));

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_last) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  // zero one entry per cycle while clearing, otherwise take the item's write
  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing_q;

endmodule : srdl_ring

`default_nettype wire

// ===== src/srdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// srdl_ctrl
// Configuration registers, write position / offset / counter update and
// ring address generation for the access stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srdl_ctrl #(
  parameter int unsigned RING_DEPTH = srdl_pkg::RING_DEPTH_DEF,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [srdl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [srdl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [srdl_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic                            adv_i,
  input  wire logic                            busy_i,
  output srdl_pkg::srdl_stage_t                stat_o,
  output logic                                 mem_we_o,
  output logic      [AW-1:0]                   mem_waddr_o,
  output logic      [srdl_pkg::SAMPLE_W-1:0]   mem_wdata_o,
  output logic                                 mem_re_o,
  output logic      [AW-1:0]                   mem_raddr_o
);
  import srdl_pkg::*;

  localparam int unsigned LW = AW + 1;
  localparam int unsigned CW = (LW > LEN_CFG_W) ? LW : LEN_CFG_W;

  function automatic logic [LW-1:0] clamp_len(input logic [LEN_CFG_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (e < CW'(MIN_LEN)) begin
      e = CW'(MIN_LEN);
    end else if (e > CW'(RING_DEPTH)) begin
      e = CW'(RING_DEPTH);
    end
    return LW'(e);
  endfunction

  logic [LW-1:0]        len_q;
  logic [TGT_CFG_W-1:0] target_q;
  logic [CNT_W-1:0]     rate_hold_q;
  logic [CNT_W-1:0]     slew_int_q;

  logic [AW-1:0]        wp_q, wp_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic [CNT_W-1:0]     slew_cnt_q, slew_cnt_d;
  logic [CNT_W-1:0]     hold_cnt_q, hold_cnt_d;
  logic                 valid_b_q;
  logic [SAMPLE_W-1:0]  sample_b_q;

  logic                 accept;
  logic [LW-1:0]        top_len;
  logic [AW-1:0]        top_a;
  logic [AW-1:0]        tgt;
  logic [AW:0]          cur_ext, cur_inc, tgt_ext;
  logic [AW-1:0]        cur_step;
  logic [CNT_W:0]       slew_inc, hold_inc;
  logic                 slew_fire, hold_fire;
  logic [AW:0]          wp_inc;
  logic [LW-1:0]        rd_sum;
  logic [LW:0]          rd_diff;
  logic [AW-1:0]        rd_addr;

  // configuration: the length is saturated as it is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= clamp_len(LEN_CFG_W'(LEN_RESET));
      target_q    <= '0;
      rate_hold_q <= '0;
      slew_int_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ACTIVE_LENGTH: len_q       <= clamp_len(cfg_wdata_i[LEN_CFG_W-1:0]);
        REG_TARGET_OFFSET: target_q    <= cfg_wdata_i[TGT_CFG_W-1:0];
        REG_RATE_HOLD:     rate_hold_q <= cfg_wdata_i[CNT_W-1:0];
        REG_SLEW_INTERVAL: slew_int_q  <= cfg_wdata_i[CNT_W-1:0];
      endcase
    end
  end

  assign in_ready_o = !busy_i && (!valid_b_q || adv_i);
  assign accept     = in_valid_i && in_ready_o;

  assign top_len = len_q - LW'(1);
  assign top_a   = AW'(top_len);
  assign tgt     = (CW'(target_q) > CW'(top_len)) ? top_a : AW'(target_q);

  // slew toward the target, dead band of one either side
  always_comb begin
    cur_ext   = {1'b0, cur_q};
    tgt_ext   = {1'b0, tgt};
    cur_inc   = cur_ext + (AW+1)'(1);
    slew_inc  = {1'b0, slew_cnt_q} + (CNT_W+1)'(1);
    slew_fire = slew_inc > {1'b0, slew_int_q};
    if (cur_inc < tgt_ext) begin
      cur_step = AW'(cur_inc);
    end else if (cur_ext > tgt_ext + (AW+1)'(1)) begin
      cur_step = cur_q - AW'(1);
    end else begin
      cur_step = cur_q;
    end
    if (cur_step > top_a) begin
      cur_step = top_a;
    end
    cur_d      = slew_fire ? cur_step : cur_q;
    slew_cnt_d = slew_fire ? '0 : slew_inc[CNT_W-1:0];
  end

  // advance the write position, wrap on the active length
  always_comb begin
    hold_inc   = {1'b0, hold_cnt_q} + (CNT_W+1)'(1);
    hold_fire  = hold_inc > {1'b0, rate_hold_q};
    hold_cnt_d = hold_fire ? '0 : hold_inc[CNT_W-1:0];
    wp_inc     = hold_fire ? ({1'b0, wp_q} + (AW+1)'(1)) : {1'b0, wp_q};
    wp_d       = (wp_inc >= len_q) ? '0 : AW'(wp_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      cur_q      <= '0;
      slew_cnt_q <= '0;
      hold_cnt_q <= '0;
      valid_b_q  <= 1'b0;
    end else begin
      if (accept) begin
        wp_q       <= wp_d;
        cur_q      <= cur_d;
        slew_cnt_q <= slew_cnt_d;
        hold_cnt_q <= hold_cnt_d;
        valid_b_q  <= 1'b1;
      end else if (adv_i) begin
        valid_b_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_b_q <= sample_i;
    end
  end

  // read position: one wrap by the length when the sum passes the top
  assign rd_sum  = {1'b0, wp_q} + {1'b0, cur_q};
  assign rd_diff = {1'b0, rd_sum} - {1'b0, len_q};
  assign rd_addr = rd_diff[LW] ? AW'(rd_sum) : AW'(rd_diff[LW-1:0]);

  assign mem_we_o    = valid_b_q && adv_i;
  assign mem_re_o    = valid_b_q && adv_i;
  assign mem_waddr_o = wp_q;
  assign mem_wdata_o = sample_b_q;
  assign mem_raddr_o = rd_addr;

  assign stat_o.valid = valid_b_q;
  assign stat_o.fwd   = (rd_addr == wp_q);

endmodule : srdl_ctrl

`default_nettype wire

// ===== src/slewed_ring_delay_line_unit.sv =====
// ----------------------------------------------------------------------------
// slewed_ring_delay_line_unit
// Audio delay line over a ring memory with a slewed read offset.
// Order: an accepted item waits in stage B; the edge that advances the pipe
// writes it into the ring, issues the read and loads the output register.
// Throughput: one item per cycle while the ring is not clearing and the
// output is not stalled, set by the single ring write and read port.
// Reset: state and valid registers clear at once; the ring is then zeroed one
// entry per cycle with in_ready_o low. Config writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module slewed_ring_delay_line_unit #(
  parameter int unsigned RING_DEPTH = srdl_pkg::RING_DEPTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [srdl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [srdl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [srdl_pkg::SAMPLE_W-1:0] sample_in_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [srdl_pkg::SAMPLE_W-1:0]     sample_out_o
);
  import srdl_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);

  srdl_stage_t         stat_b;
  logic                adv;
  logic                busy;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_wdata, mem_rdata;

  logic                valid_c_q;
  logic                fwd_c_q;
  logic [SAMPLE_W-1:0] sample_c_q;

  // The whole pipe moves when the output register is free or being drained.
  assign adv = !valid_c_q || out_ready_i;

  // Stage A (accept): update write position, offset and counters.
  // Stage B: write the item into the ring and issue the read.
  srdl_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (SAMPLE_W'(sample_in_i)),
    .adv_i       (adv),
    .busy_i      (busy),
    .stat_o      (stat_b),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  srdl_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .busy_o  (busy)
  );

  // Stage C: output register. The read sees the entry before this item's
  // write, so hold the item itself for the case where both positions meet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else if (adv) begin
      valid_c_q <= stat_b.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && stat_b.valid) begin
      fwd_c_q    <= stat_b.fwd;
      sample_c_q <= mem_wdata;
    end
  end

  assign out_valid_o  = valid_c_q;
  assign sample_out_o = fwd_c_q ? sample_c_q : mem_rdata;

endmodule : slewed_ring_delay_line_unit

`default_nettype wire

// ===== tb/slewed_ring_delay_line_unit_tb.sv =====
// ----------------------------------------------------------------------------
// slewed_ring_delay_line_unit_tb
// Self-checking bench for the slewed ring delay line. Every accepted sample
// is run through a cycle-free model of the ring, the slewed read offset and
// both counters; each returned sample is matched against the oldest
// prediction. Directed corner settings come first, then randomised phases
// with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module slewed_ring_delay_line_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srdl_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int DEPTH      = RING_DEPTH_DEF;
  localparam int MAX_GAP    = 17;
  localparam int RAND_ITEMS = 650;

  // --------------------------------------------------------------------------
  // Delay line model and store of expected output samples
  // --------------------------------------------------------------------------
  class ring_delay_scoreboard;
    logic [SAMPLE_W-1:0] ring_mem [DEPTH];
    logic [SAMPLE_W-1:0] expected_samples [$];
    int                  wr_pos, cur_ofs, slew_cnt, hold_cnt;
    logic [15:0]         len_reg, tgt_reg;
    logic [14:0]         hold_reg, slew_reg;
    int                  mismatches;

    function new();
      foreach (ring_mem[i]) ring_mem[i] = '0;
      wr_pos     = 0;
      cur_ofs    = 0;
      slew_cnt   = 0;
      hold_cnt   = 0;
      len_reg    = 16'(LEN_RESET);
      tgt_reg    = '0;
      hold_reg   = '0;
      slew_reg   = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ACTIVE_LENGTH: len_reg  = data;
        REG_TARGET_OFFSET: tgt_reg  = data;
        REG_RATE_HOLD:     hold_reg = data[14:0];
        REG_SLEW_INTERVAL: slew_reg = data[14:0];
        default: ;
      endcase
    endfunction

    // Advance the model by one sample and queue the sample it returns.
    function void take_sample(logic [SAMPLE_W-1:0] s);
      int eff, top, tgt, cur, rd;
      eff = int'(len_reg);
      if (eff < MIN_LEN) eff = MIN_LEN;
      if (eff > DEPTH) eff = DEPTH;
      top = eff - 1;
      tgt = (int'(tgt_reg) > top) ? top : int'(tgt_reg);

      slew_cnt++;
      if (slew_cnt > int'(slew_reg)) begin
        cur = cur_ofs;
        if (cur < tgt - 1) cur++;
        if (cur > tgt + 1) cur--;
        if (cur > top) cur = top;
        cur_ofs  = cur;
        slew_cnt = 0;
      end

      hold_cnt++;
      if (hold_cnt > int'(hold_reg)) begin
        hold_cnt = 0;
        wr_pos++;
      end
      if (wr_pos >= eff) wr_pos = 0;

      rd = wr_pos + cur_ofs;
      if (rd > top) rd -= eff;
      rd = rd % DEPTH;

      ring_mem[wr_pos % DEPTH] = s;
      expected_samples.push_back(ring_mem[rd]);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_sample(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] exp_s;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample_out %h with nothing expected", got));
      end else begin
        exp_s = expected_samples.pop_front();
        if (got !== exp_s)
          report_mismatch($sformatf("sample_out %h, expected %h", got, exp_s));
      end
    endtask

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, stimulus signals and the block itself
  // --------------------------------------------------------------------------
  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_idx_i;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out_o;

  ring_delay_scoreboard board;
  int items_taken   = 0;
  int results_taken = 0;
  bit tx_idle       = 1'b1;
  bit rx_idle       = 1'b1;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  slewed_ring_delay_line_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  // Sample both handshakes at the rising edge. The drivers only watch the
  // counters at the falling edge, so nothing here races with them.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        board.take_sample(sample_in_i);
        items_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        board.check_sample(sample_out_o);
        results_taken++;
      end
    end
  end

  // Receiver: stall for a random number of cycles, then hold ready until a
  // sample is taken. With rx_idle clear, ready simply stays high.
  initial begin : receiver
    int gap, prev;
    forever begin
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      prev = results_taken;
      do @(negedge clk_i); while (results_taken == prev);
    end
  end

  // Offer one sample after a random gap and hold it until it is taken.
  // Starts and ends on a falling edge; valid is left high for back-to-back use.
  task automatic send_sample(logic [SAMPLE_W-1:0] value);
    int gap, prev;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= value;
    prev = items_taken;
    do @(negedge clk_i); while (items_taken == prev);
  endtask

  // Drop valid and hold off until every predicted sample has come back, then
  // allow the pipeline to settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all four registers on consecutive cycles; only called while idle.
  task automatic write_regs(logic [15:0] len, logic [15:0] tgt,
                            logic [14:0] hold, logic [14:0] slew);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ACTIVE_LENGTH;
    cfg_wdata_i <= len;
    board.set_reg(REG_ACTIVE_LENGTH, len);
    @(negedge clk_i);
    cfg_idx_i   <= REG_TARGET_OFFSET;
    cfg_wdata_i <= tgt;
    board.set_reg(REG_TARGET_OFFSET, tgt);
    @(negedge clk_i);
    cfg_idx_i   <= REG_RATE_HOLD;
    cfg_wdata_i <= {1'b0, hold};
    board.set_reg(REG_RATE_HOLD, {1'b0, hold});
    @(negedge clk_i);
    cfg_idx_i   <= REG_SLEW_INTERVAL;
    cfg_wdata_i <= {1'b0, slew};
    board.set_reg(REG_SLEW_INTERVAL, {1'b0, slew});
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int          sent, phase_no, phase_len, pause_at, k, len_v;
    logic [15:0] len_w, tgt_w, smp;
    logic [14:0] hold_w, slew_w;

    board       = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_ACTIVE_LENGTH;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    sample_in_i <= '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Short ring with the target beyond the dead band: offset climbs to two,
    // reads run ahead of the write position. Walk the sample extremes.
    write_regs(16'd4, 16'd3, 15'd0, 15'd0);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0001);
    send_sample(16'hFFFE);
    wait_drained();

    // Length below the minimum saturates to two; the target clamps to one.
    write_regs(16'd0, 16'hFFFF, 15'd0, 15'd0);
    send_sample(16'h1234);
    send_sample(16'hEDCB);
    send_sample(16'h0F0F);
    send_sample(16'hF0F0);
    wait_drained();

    // Let the write position run to eight and the slew counter climb while
    // the slew interval is at its top.
    write_regs(16'd20, 16'd10, 15'd0, 15'h7FFF);
    for (k = 0; k < 8; k++) send_sample(16'($urandom));
    wait_drained();

    // Shrink the ring under the write position and lower the interval below
    // the running count: the position returns to zero, the slew step fires.
    write_regs(16'd5, 16'd4, 15'h7FFF, 15'd3);
    for (k = 0; k < 3; k++) send_sample(16'($urandom));
    wait_drained();

    // Length above the ring saturates to the full depth; target at the top.
    write_regs(16'hFFFF, 16'h8000, 15'd2, 15'd0);
    for (k = 0; k < 3; k++) send_sample(16'($urandom));
    wait_drained();

    // Random phases: mostly short rings and short intervals, with the odd
    // extreme setting, and gaps switched on or off per phase.
    sent     = 0;
    phase_no = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len_v = $urandom_range(0, 3);
        1:       len_v = $urandom_range(0, 65535);
        2:       len_v = $urandom_range(32768, 65535);
        3:       len_v = $urandom_range(65, 300);
        default: len_v = $urandom_range(2, 64);
      endcase
      len_w = 16'(len_v);
      case ($urandom_range(0, 5))
        0:       tgt_w = '0;
        1:       tgt_w = 16'($urandom);
        2:       tgt_w = 16'(len_v + $urandom_range(0, 3) - 1);
        default: tgt_w = 16'($urandom_range(0, (len_v > 64) ? 64 : len_v));
      endcase
      case ($urandom_range(0, 7))
        0:       hold_w = 15'h7FFF;
        1:       hold_w = 15'($urandom);
        2, 3:    hold_w = '0;
        default: hold_w = 15'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 7))
        0:       slew_w = 15'h7FFF;
        1:       slew_w = 15'($urandom);
        2, 3:    slew_w = '0;
        default: slew_w = 15'($urandom_range(1, 4));
      endcase
      write_regs(len_w, tgt_w, hold_w, slew_w);

      tx_idle   = ($urandom_range(0, 3) != 0);
      rx_idle   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(20, 80);
      // Always pause once in the first phase, now and then later on.
      pause_at  = (phase_no == 0 || $urandom_range(0, 3) == 0) ? phase_len / 2 : -1;

      for (k = 0; k < phase_len; k++) begin
        if (k == pause_at) wait_drained();
        case ($urandom_range(0, 15))
          0:       smp = 16'h7FFF;
          1:       smp = 16'h8000;
          2:       smp = 16'h0000;
          3:       smp = 16'hFFFF;
          default: smp = 16'($urandom);
        endcase
        send_sample(smp);
      end
      sent += phase_len;
      phase_no++;
      wait_drained();
    end

    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d samples never returned", board.pending()));
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Covers the ring clearing pass after reset and the slowest gaps many
  // times over.
  initial begin : watchdog
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule : slewed_ring_delay_line_unit_tb

`default_nettype wire
